// File: rtl/s_expression_tokenizer_macros.svh
// Assertion macros used by the tokenizer top level; clock clk, reset arst_n.
`ifndef S_EXPRESSION_TOKENIZER_MACROS_SVH
`define S_EXPRESSION_TOKENIZER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SXT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SXT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/sexp_tok_pkg.sv
// Package with item types, token codes and character constants of the tokenizer.
`timescale 1ns / 1ps

package sexp_tok_pkg;

	// Result queue depth, in result items
	localparam int RES_DEPTH = 4;

	// Characters with a meaning to the lexer
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef enum logic [2:0] {
		TK_CHAR     = 3'd0,
		TK_NAME_END = 3'd1,
		TK_LPAREN   = 3'd2,
		TK_RPAREN   = 3'd3,
		TK_DQUOTE   = 3'd4,
		TK_SQUOTE   = 3'd5,
		TK_EOI      = 3'd6
	} tok_kind_t;

	// Lexer mode, one-hot
	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'b0001,
		MODE_SYMBOL  = 4'b0010,
		MODE_STRING  = 4'b0100,
		MODE_COMMENT = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] name_char;
		logic       last;
	} out_item_t;

	// Up to two results caused by one input item
	typedef struct packed {
		logic [1:0] count;
		out_item_t  item0;
		out_item_t  item1;
	} lex_res_t;

	// Result item; text byte only travels with a name char
	function automatic out_item_t make_item(tok_kind_t kind, logic [7:0] ch);
		out_item_t r;
		r.token_kind = kind;
		r.name_char  = (kind == TK_CHAR) ? ch : 8'h00;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/sexp_tok_decode.sv
// Lexer step: next mode and the results caused by one input item.
`timescale 1ns / 1ps

module sexp_tok_decode import sexp_tok_pkg::*; (
	input  mode_t    mode,
	input  in_item_t item,
	output mode_t    mode_next,
	output lex_res_t res
);

	typedef struct packed {
		logic      hit;
		tok_kind_t kind;
		mode_t     mode;
	} norm_t;

	function automatic logic is_blank(logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_CR};
	endfunction

	// Normal-mode handling of a byte or end mark
	function automatic norm_t norm_step(logic [7:0] c, logic eoi);
		norm_t n;
		n.hit  = 1'b1;
		n.kind = TK_CHAR;
		n.mode = MODE_NORMAL;
		if (eoi) begin
			n.kind = TK_EOI;
		end else if (is_blank(c)) begin
			n.hit = 1'b0;
		end else if (c == CH_LPAREN) begin
			n.kind = TK_LPAREN;
		end else if (c == CH_RPAREN) begin
			n.kind = TK_RPAREN;
		end else if (c == CH_DQUOTE) begin
			n.kind = TK_DQUOTE;
			n.mode = MODE_STRING;
		end else if (c == CH_SQUOTE) begin
			n.kind = TK_SQUOTE;
		end else if (c == CH_SEMI) begin
			n.hit  = 1'b0;
			n.mode = MODE_COMMENT;
		end else begin
			n.mode = MODE_SYMBOL;
		end
		return n;
	endfunction

	logic [7:0] c;
	logic       eoi;
	norm_t      norm;
	lex_res_t   raw;

	assign c    = item.in_char;
	assign eoi  = item.end_of_input;
	assign norm = norm_step(c, eoi);

	// Mode transition and result selection
	always_comb begin
		mode_next = mode;
		raw       = '0;
		unique case (mode)
			MODE_NORMAL: begin
				mode_next = norm.mode;
				if (norm.hit) begin
					raw.count = 2'd1;
					raw.item0 = make_item(norm.kind, c);
				end
			end
			MODE_SYMBOL: begin
				if (!eoi && is_blank(c)) begin
					mode_next = MODE_NORMAL;
					raw.count = 2'd1;
					raw.item0 = make_item(TK_NAME_END, c);
				end else if (eoi || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE) begin
					// name end, then the byte as in normal mode
					mode_next = norm.mode;
					raw.count = 2'd2;
					raw.item0 = make_item(TK_NAME_END, c);
					raw.item1 = make_item(norm.kind, c);
				end else begin
					raw.count = 2'd1;
					raw.item0 = make_item(TK_CHAR, c);
				end
			end
			MODE_STRING: begin
				if (eoi) begin
					mode_next = MODE_NORMAL;
					raw.count = 2'd2;
					raw.item0 = make_item(TK_NAME_END, c);
					raw.item1 = make_item(TK_EOI, c);
				end else if (c == CH_DQUOTE) begin
					mode_next = MODE_NORMAL;
					raw.count = 2'd2;
					raw.item0 = make_item(TK_NAME_END, c);
					raw.item1 = make_item(TK_DQUOTE, c);
				end else begin
					raw.count = 2'd1;
					raw.item0 = make_item(TK_CHAR, c);
				end
			end
			MODE_COMMENT: begin
				if (eoi) begin
					mode_next = MODE_NORMAL;
					raw.count = 2'd1;
					raw.item0 = make_item(TK_EOI, c);
				end else if (c == CH_NEWLINE) begin
					mode_next = MODE_NORMAL;
				end
			end
			default: begin
				mode_next = MODE_NORMAL;
			end
		endcase
	end

	// Mark the final result of this item
	always_comb begin
		res = raw;
		if (raw.count == 2'd1) begin
			res.item0.last = 1'b1;
		end
		if (raw.count == 2'd2) begin
			res.item1.last = 1'b1;
		end
	end

endmodule

// File: rtl/sexp_tok_fifo.sv
// Result queue: takes up to two result items per cycle, hands out one while rd_stall is low.
`timescale 1ns / 1ps

module sexp_tok_fifo import sexp_tok_pkg::*; #(
	parameter int DEPTH = RES_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  lex_res_t  wr_res,
	output logic      full,
	output logic      rd_valid,
	input  logic      rd_stall,
	output out_item_t rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	out_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_ptr1;
	logic [CW-1:0]   n_wr;
	logic            rd_fire;

	assign wr_ptr1  = ptr_inc(wr_ptr_q);
	assign n_wr     = wr_en ? CW'(wr_res.count) : '0;
	assign rd_valid = (count_q != '0);
	assign rd_fire  = rd_valid && !rd_stall;
	assign rd_item  = mem_q[rd_ptr_q];
	// room for a two-result item is required before accepting input
	assign full     = (count_q > CW'(DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en && wr_res.count != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_res.item0;
		end
		if (wr_en && wr_res.count == 2'd2) begin
			mem_q[wr_ptr1] <= wr_res.item1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (n_wr == CW'(1)) begin
				wr_ptr_q <= wr_ptr1;
			end else if (n_wr == CW'(2)) begin
				wr_ptr_q <= ptr_inc(wr_ptr1);
			end
			if (rd_fire) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + n_wr - (rd_fire ? CW'(1) : CW'(0));
		end
	end

endmodule

// File: rtl/s_expression_tokenizer.sv
// Top level of the S-expression tokenizer: mode register, lexer step, result queue.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------
//  source  | src_valid | src_stall | src_item (in_item_t)
//  tokens  | tok_valid | tok_stall | tok_item (out_item_t)
//
// One input item is taken per cycle while src_stall is low; its zero, one or two
// results enter the result queue at that same edge and are shown at tok_* behind any results still held there.
// src_stall rises when the queue cannot take two more results (RES_DEPTH - 1
// or more held), so the queue depth sets how long tokens may stall without
// holding the source. Reset clears the mode to normal and empties the queue.
`timescale 1ns / 1ps
`include "s_expression_tokenizer_macros.svh"

module s_expression_tokenizer import sexp_tok_pkg::*; #(
	parameter int RES_DEPTH_P = RES_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_item
);

	mode_t    mode_q;
	mode_t    mode_next;
	lex_res_t res;
	logic     accept;

	assign accept = src_valid && !src_stall;

	// Lexer step for the offered item
	sexp_tok_decode u_decode (
		.mode      (mode_q),
		.item      (src_item),
		.mode_next (mode_next),
		.res       (res)
	);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (accept) begin
			mode_q <= mode_next;
		end
	end

	// Result queue
	sexp_tok_fifo #(
		.DEPTH (RES_DEPTH_P)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_res   (res),
		.full     (src_stall),
		.rd_valid (tok_valid),
		.rd_stall (tok_stall),
		.rd_item  (tok_item)
	);

	// Checks
	`SXT_ASSERT_NEXT(a_res_shown, accept && res.count != 2'd0, tok_valid, "results not queued")
	`SXT_ASSERT_NEXT(a_eoi_mode, accept && src_item.end_of_input, mode_q == MODE_NORMAL, "mode after end")
	`SXT_ASSERT_NEXT(a_pair_held, tok_valid && !tok_stall && !tok_item.last, tok_valid, "pair split")
	`SXT_ASSERT_NOW(a_stall_cause, src_stall, tok_valid, "stall with empty queue")

endmodule

// File: tb/sv/s_expression_tokenizer_checker.sv
// Token stream checker for the S-expression tokenizer: predicts tokens per item and compares.
`timescale 1ns / 1ps

module s_expression_tokenizer_checker import sexp_tok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_stall,
	input  in_item_t  src_item,
	input  logic      tok_valid,
	input  logic      tok_stall,
	input  out_item_t tok_item,
	output int        fail_count,
	output int        pending,
	output int        tokens_seen
);

	mode_t     lex_mode = MODE_NORMAL;
	out_item_t expected_tokens[$];
	int        errs = 0;
	int        checked = 0;

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_CR;
	endfunction

	// Queue one expected token; text byte only rides with a name char
	function automatic void push_token(tok_kind_t kind, logic [7:0] ch);
		out_item_t t;
		t.token_kind = kind;
		t.name_char  = (kind == TK_CHAR) ? ch : 8'h00;
		t.last       = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	// Handling of one byte or end mark from normal mode
	function automatic void lex_normal(logic [7:0] c, logic eoi);
		if (eoi) begin
			push_token(TK_EOI, 8'h00);
		end else if (is_blank(c)) begin
		end else if (c == CH_LPAREN) begin
			push_token(TK_LPAREN, 8'h00);
		end else if (c == CH_RPAREN) begin
			push_token(TK_RPAREN, 8'h00);
		end else if (c == CH_DQUOTE) begin
			lex_mode = MODE_STRING;
			push_token(TK_DQUOTE, 8'h00);
		end else if (c == CH_SQUOTE) begin
			push_token(TK_SQUOTE, 8'h00);
		end else if (c == CH_SEMI) begin
			lex_mode = MODE_COMMENT;
		end else begin
			lex_mode = MODE_SYMBOL;
			push_token(TK_CHAR, c);
		end
	endfunction

	// Tokens caused by one accepted item; the final one carries last
	function automatic void predict_tokens(in_item_t it);
		int         prior_size;
		logic [7:0] c;
		logic       eoi;
		prior_size = expected_tokens.size();
		c          = it.in_char;
		eoi        = it.end_of_input;
		case (lex_mode)
			MODE_SYMBOL: begin
				if (!eoi && is_blank(c)) begin
					lex_mode = MODE_NORMAL;
					push_token(TK_NAME_END, 8'h00);
				end else if (eoi || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE) begin
					lex_mode = MODE_NORMAL;
					push_token(TK_NAME_END, 8'h00);
					lex_normal(c, eoi);
				end else begin
					push_token(TK_CHAR, c);
				end
			end
			MODE_STRING: begin
				if (eoi) begin
					lex_mode = MODE_NORMAL;
					push_token(TK_NAME_END, 8'h00);
					push_token(TK_EOI, 8'h00);
				end else if (c == CH_DQUOTE) begin
					lex_mode = MODE_NORMAL;
					push_token(TK_NAME_END, 8'h00);
					push_token(TK_DQUOTE, 8'h00);
				end else begin
					push_token(TK_CHAR, c);
				end
			end
			MODE_COMMENT: begin
				if (eoi) begin
					lex_mode = MODE_NORMAL;
					push_token(TK_EOI, 8'h00);
				end else if (c == CH_NEWLINE) begin
					lex_mode = MODE_NORMAL;
				end
			end
			default: lex_normal(c, eoi);
		endcase
		if (expected_tokens.size() > prior_size)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	// Compare tokens first: a token leaving at this edge comes from earlier items
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			lex_mode = MODE_NORMAL;
			expected_tokens.delete();
		end else begin
			if (tok_valid && !tok_stall) begin
				checked++;
				if (expected_tokens.size() == 0) begin
					errs++;
					$display("%0t: token with none expected: kind %0d char 0x%02h last %0d",
						$time, tok_item.token_kind, tok_item.name_char, tok_item.last);
				end else begin
					want = expected_tokens.pop_front();
					if (tok_item.token_kind !== want.token_kind) begin
						errs++;
						$display("%0t: token_kind expected %0d, got %0d",
							$time, want.token_kind, tok_item.token_kind);
					end
					if (tok_item.name_char !== want.name_char) begin
						errs++;
						$display("%0t: name_char expected 0x%02h, got 0x%02h",
							$time, want.name_char, tok_item.name_char);
					end
					if (tok_item.last !== want.last) begin
						errs++;
						$display("%0t: last expected %0d, got %0d",
							$time, want.last, tok_item.last);
					end
				end
			end
			if (src_valid && !src_stall)
				predict_tokens(src_item);
		end
		pending     <= expected_tokens.size();
		fail_count  <= errs;
		tokens_seen <= checked;
	end

endmodule

// File: tb/sv/tb_s_expression_tokenizer.sv
// Testbench top for the S-expression tokenizer: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module tb_s_expression_tokenizer;
	import sexp_tok_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 280;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	in_item_t  src_item = '0;
	logic      tok_stall = 1'b0;
	logic      src_stall;
	logic      tok_valid;
	out_item_t tok_item;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int items_sent = 0;
	int directed_items = 0;
	int fail_count;
	int pending;
	int tokens_seen;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	s_expression_tokenizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	s_expression_tokenizer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_item    (src_item),
		.tok_valid   (tok_valid),
		.tok_stall   (tok_stall),
		.tok_item    (tok_item),
		.fail_count  (fail_count),
		.pending     (pending),
		.tokens_seen (tokens_seen)
	);

	// Token-side stall: random per phase, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tok_stall <= 1'b1;
		end else begin
			tok_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("s_expression_tokenizer verification failed");
		$finish;
	end

	// Offer one item after random idle cycles; stall is sampled at the falling edge
	task automatic send_byte(logic [7:0] ch, logic eoi);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item.in_char <= ch;
		src_item.end_of_input <= eoi;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !src_stall;
			@(posedge clk);
		end
		items_sent++;
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic send_blank();
		case ($urandom_range(3))
			0: send_byte(CH_SPACE, 1'b0);
			1: send_byte(CH_TAB, 1'b0);
			2: send_byte(CH_NEWLINE, 1'b0);
			default: send_byte(CH_CR, 1'b0);
		endcase
	endtask

	// String text up to the closing quote; sometimes cut off by end of input
	task automatic send_string_body();
		logic [7:0] c;
		int         len;
		len = $urandom_range(6);
		for (int i = 0; i < len; i++) begin
			do c = any_byte(); while (c == CH_DQUOTE);
			send_byte(c, 1'b0);
		end
		if ($urandom_range(99) < 90)
			send_byte(CH_DQUOTE, 1'b0);
		else
			send_byte(any_byte(), 1'b1);
	endtask

	// Symbol of random bytes, closed by each of the ways a symbol can end
	task automatic send_symbol();
		logic [7:0] c;
		int         len;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			do c = any_byte();
			while (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_CR ||
				c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE ||
				(i == 0 && (c == CH_SEMI || c == CH_SQUOTE)));
			send_byte(c, 1'b0);
		end
		case ($urandom_range(5))
			0, 1: send_blank();
			2: send_byte(CH_LPAREN, 1'b0);
			3: send_byte(CH_RPAREN, 1'b0);
			4: begin
				send_byte(CH_DQUOTE, 1'b0);
				send_string_body();
			end
			default: send_byte(any_byte(), 1'b1);
		endcase
	endtask

	task automatic send_comment();
		logic [7:0] c;
		int         len;
		send_byte(CH_SEMI, 1'b0);
		len = $urandom_range(5);
		for (int i = 0; i < len; i++) begin
			do c = any_byte(); while (c == CH_NEWLINE);
			send_byte(c, 1'b0);
		end
		if ($urandom_range(99) < 85)
			send_byte(CH_NEWLINE, 1'b0);
		else
			send_byte(any_byte(), 1'b1);
	endtask

	// Mostly well-formed lexemes, some bare end marks and random noise
	task automatic send_lexeme();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			send_symbol();
		end else if (pick < 48) begin
			send_byte(CH_DQUOTE, 1'b0);
			send_string_body();
		end else if (pick < 58) begin
			send_comment();
		end else if (pick < 66) begin
			send_byte(CH_LPAREN, 1'b0);
		end else if (pick < 74) begin
			send_byte(CH_RPAREN, 1'b0);
		end else if (pick < 79) begin
			send_byte(CH_SQUOTE, 1'b0);
		end else if (pick < 89) begin
			send_blank();
		end else if (pick < 93) begin
			send_byte(any_byte(), 1'b1);
		end else begin
			send_byte(any_byte(), 1'($urandom_range(1)));
		end
	endtask

	task automatic run_phase(int idle, int stall, bit with_hold, int count);
		int stop;
		idle_pct  = idle;
		stall_pct = stall;
		if (with_hold)
			hold_req++;
		stop = items_sent + count;
		while (items_sent < stop)
			send_lexeme();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-character tokens and whitespace
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_SQUOTE, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		// Symbol holding ';', quote and 0xFF, closed by ')'
		send_byte(8'h61, 1'b0);
		send_byte(CH_SEMI, 1'b0);
		send_byte(CH_SQUOTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		// Empty string
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		// End of input inside a string, a comment and a symbol, then once more
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(CH_SEMI, 1'b0);
		send_byte(8'h7A, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h62, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hAA, 1'b1);
		// Zero byte as a symbol; symbol closed by a quote and by '('
		send_byte(8'h00, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'h63, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(8'h64, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		directed_items = items_sent;

		run_phase(0, 0, 1'b1, ITEMS_PER_PHASE);
		run_phase(87, 0, 1'b0, ITEMS_PER_PHASE);
		run_phase(0, 87, 1'b0, ITEMS_PER_PHASE);
		run_phase(11, 11, 1'b1, ITEMS_PER_PHASE);
		src_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);

		$display("Sent %0d characters and end marks (%0d directed), %0d tokens checked.",
			items_sent, directed_items, tokens_seen);
		$display("Phases: free flow, sparse source, heavy token stall, light both; two long hold-offs.");
		if (fail_count == 0 && pending == 0)
			$display("s_expression_tokenizer verification clean");
		else
			$display("s_expression_tokenizer verification failed");
		$finish;
	end

endmodule
